// ===== hdl/tstm_pkg.sv =====
// tstm_pkg: shared types and constants of the touch sample trimmed mean filter
// beat structs, controller state, command and status groups
// no dependencies
package tstm_pkg;

    localparam int DEF_MAX_SAMPLES  = 18;
    localparam int DEF_MAX_ATTEMPTS = 10;

    localparam int SAMPLE_W  = 13;
    localparam int CHANNEL_W = 8;
    localparam int CFG_W     = 5;

    localparam logic [SAMPLE_W-1:0] INVALID_ABOVE = 13'd4096;
    localparam logic [SAMPLE_W-1:0] LOW_RESET     = 13'd5000;
    localparam logic [SAMPLE_W-1:0] SETTLE_SPREAD = 13'd50;
    localparam logic [CFG_W-1:0]    CFG_RESET     = 5'd15;
    localparam logic [CFG_W-1:0]    CFG_MIN_GROUP = 5'd3;

    typedef struct packed {
        logic [SAMPLE_W-1:0]  sample;
        logic                 start_req;
        logic [CHANNEL_W-1:0] channel_cmd;
    } in_beat_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0]  average;
        logic                 failed;
        logic [CHANNEL_W-1:0] result_channel;
    } out_beat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MEASURE,
        ST_CHECK,
        ST_DIVIDE
    } state_t;

    typedef struct packed {
        logic start;        // begin a measurement, latch command byte
        logic sample;       // fold one sample into the group
        logic retry;        // drop the group, count one more attempt
        logic div_start;    // launch the trimmed mean division
        logic load_direct;  // result without division
        logic load_div;     // result from the divider
    } cmd_t;

    typedef struct packed {
        logic group_end;    // next sample completes the group
        logic settled;
        logic last_try;
        logic need_div;
        logic div_done;
    } status_t;

endpackage

// ===== hdl/tstm_div.sv =====
// tstm_div: restoring divider, one quotient bit per cycle
// used by tstm_datapath; no package dependency
module tstm_div #(
    parameter int DIVIDEND_W = 17,
    parameter int DIVISOR_W  = 5
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  div_reg, div_next;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  ge;

    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, div_reg};
    assign ge    = trial >= {1'b0, div_reg};

    always_comb begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        if (start) begin
            busy_next  = 1'b1;
            count_next = CNT_W'(DIVIDEND_W);
            quo_next   = dividend;
            rem_next   = '0;
            div_next   = divisor;
        end else if (busy_reg) begin
            rem_next   = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            quo_next   = {quo_reg[DIVIDEND_W-2:0], ge};
            count_next = count_reg - CNT_W'(1);
            if (count_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== hdl/tstm_datapath.sv =====
// tstm_datapath: group statistics, config register, divider and result register
// depends on tstm_pkg and tstm_div
module tstm_datapath #(
    parameter int MAX_SAMPLES  = tstm_pkg::DEF_MAX_SAMPLES,
    parameter int MAX_ATTEMPTS = tstm_pkg::DEF_MAX_ATTEMPTS
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic [tstm_pkg::CFG_W-1:0] cfg_data,
    input  tstm_pkg::in_beat_t      s_data,
    input  tstm_pkg::cmd_t          cmd,
    output tstm_pkg::status_t       status,
    output tstm_pkg::out_beat_t     m_data
);

    import tstm_pkg::*;

    localparam int POS_W = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W = $clog2(MAX_SAMPLES * 4096 + 1);
    localparam int ATT_W = $clog2(MAX_ATTEMPTS + 1);
    localparam int CMP_W = (POS_W > CFG_W) ? POS_W : CFG_W;

    logic [CFG_W-1:0]     cfg_reg;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [SAMPLE_W-1:0]  low_reg, low_next;
    logic [SAMPLE_W-1:0]  high_reg, high_next;
    logic [SAMPLE_W-1:0]  last_smp_reg, last_smp_next;
    logic [POS_W-1:0]     vcount_reg, vcount_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [ATT_W-1:0]     attempt_reg, attempt_next;
    logic                 last_inv_reg, last_inv_next;
    logic [CHANNEL_W-1:0] channel_reg, channel_next;
    out_beat_t            out_reg, out_next;

    logic [CMP_W-1:0]     cfg_ext;
    logic [CMP_W-1:0]     n_ext;
    logic [POS_W-1:0]     n_cur;
    logic [POS_W:0]       pos_inc;
    logic                 s_invalid;
    logic [SAMPLE_W-1:0]  spread;
    logic [SUM_W-1:0]     trimmed;
    logic [SAMPLE_W-1:0]  avg_direct;
    logic [SAMPLE_W-1:0]  avg_div;
    logic                 div_done;
    logic [SUM_W-1:0]     quotient;

    // group size: below three means one, capped at the maximum
    assign cfg_ext = CMP_W'(cfg_reg);
    always_comb begin
        if (cfg_reg < CFG_MIN_GROUP) begin
            n_ext = CMP_W'(1);
        end else if (cfg_ext > CMP_W'(MAX_SAMPLES)) begin
            n_ext = CMP_W'(MAX_SAMPLES);
        end else begin
            n_ext = cfg_ext;
        end
    end
    assign n_cur = n_ext[POS_W-1:0];

    assign pos_inc   = {1'b0, pos_reg} + (POS_W+1)'(1);
    assign s_invalid = s_data.sample > INVALID_ABOVE;
    assign spread    = high_reg - low_reg;
    assign trimmed   = sum_reg - SUM_W'(low_reg) - SUM_W'(high_reg);

    assign status.group_end = pos_inc >= {1'b0, n_cur};
    assign status.settled   = (vcount_reg != '0) && (spread < SETTLE_SPREAD);
    assign status.last_try  = (attempt_reg + ATT_W'(1)) >= ATT_W'(MAX_ATTEMPTS);
    assign status.need_div  = !last_inv_reg && (n_cur != POS_W'(1))
                              && (vcount_reg > POS_W'(1));
    assign status.div_done  = div_done;

    // n of one: the result is the last sample itself
    assign avg_direct = (!last_inv_reg && n_cur == POS_W'(1)) ? last_smp_reg : '0;
    assign avg_div    = (quotient > SUM_W'(INVALID_ABOVE)) ? INVALID_ABOVE
                                                           : quotient[SAMPLE_W-1:0];

    tstm_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (POS_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (trimmed),
        .divisor  (n_cur - POS_W'(2)),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb begin
        sum_next      = sum_reg;
        low_next      = low_reg;
        high_next     = high_reg;
        last_smp_next = last_smp_reg;
        vcount_next   = vcount_reg;
        pos_next      = pos_reg;
        attempt_next  = attempt_reg;
        last_inv_next = last_inv_reg;
        channel_next  = channel_reg;
        out_next      = out_reg;
        priority if (cmd.start) begin
            sum_next      = '0;
            low_next      = LOW_RESET;
            high_next     = '0;
            vcount_next   = '0;
            pos_next      = '0;
            last_inv_next = 1'b0;
            attempt_next  = '0;
            channel_next  = s_data.channel_cmd;
        end else if (cmd.sample) begin
            pos_next      = pos_inc[POS_W-1:0];
            last_inv_next = s_invalid;
            last_smp_next = s_data.sample;
            if (!s_invalid) begin
                sum_next    = sum_reg + SUM_W'(s_data.sample);
                vcount_next = vcount_reg + POS_W'(1);
                if (s_data.sample < low_reg) begin
                    low_next = s_data.sample;
                end
                if (s_data.sample > high_reg) begin
                    high_next = s_data.sample;
                end
            end
        end else if (cmd.retry || cmd.load_direct || cmd.load_div) begin
            sum_next      = '0;
            low_next      = LOW_RESET;
            high_next     = '0;
            vcount_next   = '0;
            pos_next      = '0;
            last_inv_next = 1'b0;
            attempt_next  = cmd.retry ? attempt_reg + ATT_W'(1) : '0;
            if (cmd.load_direct) begin
                out_next.average        = avg_direct;
                out_next.failed         = last_inv_reg;
                out_next.result_channel = channel_reg;
            end else if (cmd.load_div) begin
                out_next.average        = avg_div;
                out_next.failed         = 1'b0;
                out_next.result_channel = channel_reg;
            end
        end else begin
            // hold while idle, between samples or while dividing
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg      <= CFG_RESET;
            sum_reg      <= '0;
            low_reg      <= LOW_RESET;
            high_reg     <= '0;
            last_smp_reg <= '0;
            vcount_reg   <= '0;
            pos_reg      <= '0;
            attempt_reg  <= '0;
            last_inv_reg <= 1'b0;
            channel_reg  <= '0;
        end else begin
            if (cfg_we) begin
                cfg_reg <= cfg_data;
            end
            sum_reg      <= sum_next;
            low_reg      <= low_next;
            high_reg     <= high_next;
            last_smp_reg <= last_smp_next;
            vcount_reg   <= vcount_next;
            pos_reg      <= pos_next;
            attempt_reg  <= attempt_next;
            last_inv_reg <= last_inv_next;
            channel_reg  <= channel_next;
        end
        out_reg <= out_next;
    end

    assign m_data = out_reg;

    dp_minmax_order: assert property (@(posedge aclk) disable iff (!aresetn)
        vcount_reg != '0 |-> high_reg >= low_reg)
        else $error("group maximum below minimum with valid samples present");

    dp_attempt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        attempt_reg < ATT_W'(MAX_ATTEMPTS))
        else $error("attempt count beyond the attempt limit");

    // a group size shrunk mid-group may leave the position above the current size
    dp_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_W'(MAX_SAMPLES) && vcount_reg <= pos_reg)
        else $error("group position or valid count out of range");

endmodule

// ===== hdl/tstm_ctrl.sv =====
// tstm_ctrl: measurement sequencer and result valid flag
// depends on tstm_pkg
module tstm_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              start_req,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  tstm_pkg::status_t status,
    output tstm_pkg::cmd_t    cmd
);

    import tstm_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    assign accept = s_valid && s_ready;

    // outputs
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                cmd.start = s_valid && start_req;
            end
            ST_MEASURE: begin
                // hold samples while a result waits, a group end would need the register
                s_ready = !out_valid_reg;
                if (s_valid && !out_valid_reg) begin
                    cmd.start  = start_req;
                    cmd.sample = !start_req;
                end
            end
            ST_CHECK: begin
                if (!status.settled && !status.last_try) begin
                    cmd.retry = 1'b1;
                end else if (status.need_div) begin
                    cmd.div_start = 1'b1;
                end else begin
                    cmd.load_direct = 1'b1;
                end
            end
            ST_DIVIDE: begin
                cmd.load_div = status.div_done;
            end
            default: begin
                cmd     = '0;
                s_ready = 1'b0;
            end
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && start_req) begin
                    state_next = ST_MEASURE;
                end
            end
            ST_MEASURE: begin
                if (accept && !start_req && status.group_end) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (!status.settled && !status.last_try) begin
                    state_next = ST_MEASURE;
                end else if (status.need_div) begin
                    state_next = ST_DIVIDE;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIVIDE: begin
                if (status.div_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        priority if (cmd.load_direct || cmd.load_div) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid = out_valid_reg;

    ctrl_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load_direct || cmd.load_div) |-> !out_valid_reg)
        else $error("result loaded over a pending beat");

    ctrl_idle_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && accept && !start_req) |=> state_reg == ST_IDLE)
        else $error("sample beat while idle left the idle state");

    ctrl_load_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load_direct || cmd.load_div) |=> (state_reg == ST_IDLE && out_valid_reg))
        else $error("result load did not end the measurement");

    ctrl_div_launch: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> (status.need_div && state_reg == ST_CHECK))
        else $error("division launched without a trimmed mean to form");

endmodule

// ===== hdl/touch_sample_trimmed_mean_top.sv =====
// touch sample trimmed mean filter: one sample beat per cycle inside a group while
// no earlier result waits for the receiver; a beat that completes a group moves the
// sequencer to the check state, and a trimmed mean then runs the bit-serial divider
// in the divide state; a direct result is loaded from the check state, a divided one
// when the divider is done; synchronous active-low reset clears all group state,
// idles the sequencer and sets the group size register to 15; no clearing pass
module touch_sample_trimmed_mean_top #(
    parameter int MAX_SAMPLES  = tstm_pkg::DEF_MAX_SAMPLES,
    parameter int MAX_ATTEMPTS = tstm_pkg::DEF_MAX_ATTEMPTS
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [tstm_pkg::CFG_W-1:0] cfg_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  tstm_pkg::in_beat_t         s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output tstm_pkg::out_beat_t        m_data
);

    import tstm_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    tstm_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .start_req (s_data.start_req),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .status    (status),
        .cmd       (cmd)
    );

    tstm_datapath #(
        .MAX_SAMPLES  (MAX_SAMPLES),
        .MAX_ATTEMPTS (MAX_ATTEMPTS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .s_data   (s_data),
        .cmd      (cmd),
        .status   (status),
        .m_data   (m_data)
    );

endmodule

// ===== tb/touch_sample_trimmed_mean_checker.sv =====
// checker for the touch sample trimmed mean filter: watches the config, sample and
// result channels, predicts every result beat and compares it field by field
// depends on tstm_pkg
`timescale 1ns / 100ps
module touch_sample_trimmed_mean_checker #(
    parameter int MAX_SAMPLES  = tstm_pkg::DEF_MAX_SAMPLES,
    parameter int MAX_ATTEMPTS = tstm_pkg::DEF_MAX_ATTEMPTS
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [tstm_pkg::CFG_W-1:0] cfg_data,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  tstm_pkg::in_beat_t         s_data,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  tstm_pkg::out_beat_t        m_data,
    output int                         fail_count,
    output int                         pending
);
    import tstm_pkg::*;

    logic [CFG_W-1:0]     group_reg;
    logic [16:0]          sum_acc;
    logic [SAMPLE_W-1:0]  low_val;
    logic [SAMPLE_W-1:0]  high_val;
    logic [4:0]           valid_cnt;
    logic [4:0]           position;
    logic [3:0]           attempts;
    logic                 last_bad;
    logic                 measuring;
    logic [CHANNEL_W-1:0] held_chan;

    out_beat_t expected_means[$];
    out_beat_t want;
    int        fails     = 0;
    int        pending_n = 0;

    assign fail_count = fails;
    assign pending    = pending_n;

    function automatic int unsigned group_size(input logic [CFG_W-1:0] r);
        if (r < CFG_MIN_GROUP) return 1;
        if (32'(r) > MAX_SAMPLES) return MAX_SAMPLES;
        return 32'(r);
    endfunction

    task automatic clear_group();
        sum_acc   = '0;
        low_val   = LOW_RESET;
        high_val  = '0;
        valid_cnt = '0;
        position  = '0;
        last_bad  = 1'b0;
    endtask

    task automatic fold_beat(input in_beat_t b);
        int unsigned n;
        logic [16:0] quotient;
        logic        settled;
        out_beat_t   res;
        if (b.start_req) begin
            clear_group();
            attempts  = '0;
            measuring = 1'b1;
            held_chan = b.channel_cmd;
        end else if (measuring) begin
            n = group_size(group_reg);
            if (b.sample > INVALID_ABOVE) begin
                last_bad = 1'b1;
            end else begin
                last_bad = 1'b0;
                sum_acc  = sum_acc + 17'(b.sample);
                if (b.sample < low_val) low_val = b.sample;
                if (b.sample > high_val) high_val = b.sample;
                valid_cnt = valid_cnt + 5'd1;
            end
            position = position + 5'd1;
            // a shrunk group size ends the group on the next beat
            if (32'(position) >= n) begin
                settled = (valid_cnt != 0) && ((high_val - low_val) < SETTLE_SPREAD);
                if (!settled && (int'(attempts) + 1 < MAX_ATTEMPTS)) begin
                    attempts = attempts + 4'd1;
                    clear_group();
                end else begin
                    res.failed         = last_bad;
                    res.average        = '0;
                    res.result_channel = held_chan;
                    if (!last_bad) begin
                        if (n == 1) begin
                            res.average = b.sample;
                        end else if (valid_cnt >= 2) begin
                            quotient = 17'((32'(sum_acc) - 32'(low_val) - 32'(high_val))
                                           / (n - 32'd2));
                            res.average = (quotient > 17'(INVALID_ABOVE))
                                          ? INVALID_ABOVE : quotient[SAMPLE_W-1:0];
                        end
                    end
                    expected_means.push_back(res);
                    clear_group();
                    attempts  = '0;
                    measuring = 1'b0;
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            group_reg = CFG_RESET;
            clear_group();
            attempts  = '0;
            measuring = 1'b0;
            held_chan = '0;
            expected_means.delete();
        end else begin
            // results first, so a beat accepted on the same edge cannot be matched
            if (m_valid && m_ready) begin
                if (expected_means.size() == 0) begin
                    fails = fails + 1;
                    if (fails <= 10)
                        $display("unexpected result beat: avg %0d failed %0d chan %0h",
                                 m_data.average, m_data.failed, m_data.result_channel);
                end else begin
                    want = expected_means.pop_front();
                    if (m_data.average !== want.average || m_data.failed !== want.failed ||
                        m_data.result_channel !== want.result_channel) begin
                        fails = fails + 1;
                        if (fails <= 10)
                            $display({"mismatch: expected avg %0d failed %0d chan %0h,",
                                      " got avg %0d failed %0d chan %0h"},
                                     want.average, want.failed, want.result_channel,
                                     m_data.average, m_data.failed, m_data.result_channel);
                    end
                end
            end
            if (cfg_valid && cfg_ready) group_reg = cfg_data;
            if (s_valid && s_ready) fold_beat(s_data);
        end
        pending_n = expected_means.size();
    end

endmodule

// ===== tb/tb.sv =====
// testbench top for the touch sample trimmed mean filter: clock, reset, stimulus
// and verdict; the checker module does the prediction and comparison
// depends on tstm_pkg, touch_sample_trimmed_mean_top and the checker
`timescale 1ns / 100ps
module tb;
    import tstm_pkg::*;

    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 2000;
    localparam int RANDOM_BEATS  = 390;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 s_valid   = 1'b0;
    in_beat_t             s_data    = '0;
    logic                 m_ready   = 1'b0;
    logic                 cfg_ready;
    logic                 s_ready;
    logic                 m_valid;
    out_beat_t            m_data;

    int fail_count;
    int pending;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int quiet         = 0;
    int beats_sent    = 0;
    int gsize         = 15;

    always #2 aclk = ~aclk;

    touch_sample_trimmed_mean_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    touch_sample_trimmed_mean_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task automatic send_beat(input logic [SAMPLE_W-1:0] smp, input logic st,
                             input logic [CHANNEL_W-1:0] ch);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{sample: smp, start_req: st, channel_cmd: ch};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        beats_sent = beats_sent + 1;
    endtask

    task automatic send_start(input logic [CHANNEL_W-1:0] ch);
        send_beat(SAMPLE_W'($urandom_range(0, 8191)), 1'b1, ch);
    endtask

    task automatic send_sample(input logic [SAMPLE_W-1:0] smp);
        send_beat(smp, 1'b0, CHANNEL_W'($urandom_range(0, 255)));
    endtask

    // stop offering, let every predicted result out, then give the divider time
    task automatic wait_drain();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_group_size(input logic [CFG_W-1:0] v);
        wait_drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        gsize = (v < CFG_MIN_GROUP) ? 1
              : ((int'(v) > DEF_MAX_SAMPLES) ? DEF_MAX_SAMPLES : int'(v));
    endtask

    task automatic run_measurement();
        int unsigned base;
        int unsigned k;
        int unsigned g;
        int unsigned i;
        int unsigned mode;
        logic [SAMPLE_W-1:0] smp;
        send_start(CHANNEL_W'($urandom_range(0, 255)));
        // broken sequence: up to a full group of samples, then a restart
        if ($urandom_range(0, 99) < 6) begin
            k = $urandom_range(1, gsize);
            for (i = 0; i < k; i++) send_sample(SAMPLE_W'($urandom_range(0, 8191)));
            send_start(CHANNEL_W'($urandom_range(0, 255)));
        end
        if (gsize <= 5 && $urandom_range(0, 99) < 12) k = 9 + $urandom_range(0, 1);
        else k = $urandom_range(0, 2);
        for (g = 0; g <= k; g++) begin
            base = $urandom_range(0, 4047);
            mode = (g < k) ? (($urandom_range(0, 99) < 15) ? 2 : 1) : 0;
            for (i = 0; i < gsize; i++) begin
                if (mode == 2 || $urandom_range(0, 99) < 8)
                    smp = SAMPLE_W'($urandom_range(4097, 8191));
                else if (mode == 1) smp = SAMPLE_W'($urandom_range(0, 4096));
                else smp = SAMPLE_W'(base + $urandom_range(0, 49));
                send_sample(smp);
            end
        end
    endtask

    initial begin
        logic [CFG_W-1:0] size_pick[12];
        int next_cfg;
        int next_phase;
        int phase;
        int i;
        size_pick = '{5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7,
                      5'd15, 5'd18, 5'd19, 5'd31};
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // single-sample groups: extremes, invalid last sample, idle sample
        write_group_size(5'd0);
        send_beat(13'd8191, 1'b1, 8'hFF);
        send_sample(13'd0);
        send_beat(13'd0, 1'b1, 8'h00);
        send_sample(13'd4096);
        send_beat(13'd1234, 1'b1, 8'h3C);
        send_sample(13'd4097);
        send_sample(13'd7);

        // restart mid-measurement, a group with no valid sample, failed result
        write_group_size(5'd3);
        send_beat(13'd0, 1'b1, 8'hA5);
        send_sample(13'd10);
        send_beat(13'd4096, 1'b1, 8'h5A);
        repeat (3) send_sample(13'd8191);
        send_sample(13'd4096);
        send_sample(13'd4090);
        send_sample(13'd8191);

        // size shrunk mid-group: group ends at once and the average saturates
        write_group_size(5'd31);
        send_beat(13'd8191, 1'b1, 8'h81);
        repeat (4) send_sample(13'd4096);
        write_group_size(5'd3);
        send_sample(13'd4096);

        // size 2 behaves as 1
        write_group_size(5'd2);
        send_beat(13'd100, 1'b1, 8'h7E);
        send_sample(13'd77);

        // long receiver hold-off while the sender keeps offering beats
        write_group_size(5'd1);
        hold_requests <= hold_requests + 1;
        for (i = 0; i < 16; i++) begin
            send_start(CHANNEL_W'($urandom_range(0, 255)));
            send_sample(SAMPLE_W'($urandom_range(0, 8191)));
        end
        wait_drain();

        next_cfg   = beats_sent;
        next_phase = beats_sent + 110;
        phase      = 0;
        i          = beats_sent + RANDOM_BEATS;
        while (beats_sent < i) begin
            if (beats_sent >= next_cfg) begin
                write_group_size(size_pick[4'($urandom_range(0, 11))]);
                next_cfg = beats_sent + 60;
            end
            if (beats_sent >= next_phase) begin
                phase = (phase + 1) % 4;
                send_idle_pct = (phase == 1) ? 57 : ((phase == 3) ? 14 : 0);
                stall_pct     = (phase == 2) ? 57 : ((phase == 3) ? 14 : 0);
                next_phase = beats_sent + 110;
            end
            // ignored noise while idle
            if ($urandom_range(0, 99) < 8) send_sample(SAMPLE_W'($urandom_range(0, 8191)));
            run_measurement();
        end

        wait_drain();
        @(negedge aclk);
        if (fail_count == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end

endmodule
